@@ hdl/fcd_pkg.sv @@
// shared types, constants and helpers of the frame chunk decoder
package fcd_pkg;

  localparam int unsigned MAX_DIMENSION = 2048;
  localparam int unsigned PALETTE_BYTES = 768;

  localparam logic [22:0] CUR_MAX  = 23'h7FFFFF;
  localparam logic [11:0] PAL_MAX  = 12'hFFF;
  localparam logic [15:0] FRAME_ID = 16'hF1FA;
  localparam logic [15:0] OP_SKIP  = 16'hC000;
  localparam logic [15:0] OP_LAST  = 16'h8000;

  localparam logic [11:0] WIDTH_RST  = 12'd320;
  localparam logic [11:0] HEIGHT_RST = 12'd200;
  localparam logic [22:0] AREA_RST   = 23'd64000;

  localparam logic [15:0] CK_PAL8  = 16'd4;
  localparam logic [15:0] CK_PAL6  = 16'd11;
  localparam logic [15:0] CK_WDLT  = 16'd7;
  localparam logic [15:0] CK_BDLT  = 16'd12;
  localparam logic [15:0] CK_CLEAR = 16'd13;
  localparam logic [15:0] CK_BRUN  = 16'd15;
  localparam logic [15:0] CK_RAW   = 16'd16;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic TGT_IMAGE   = 1'b0;
  localparam logic TGT_PALETTE = 1'b1;

  typedef enum logic [4:0] {
    PH_IDLE, PH_REC_SIZE, PH_REC_TYPE, PH_FRM_HDR, PH_CHK_SIZE, PH_CHK_TYPE,
    PH_CHK_SKIP, PH_REC_SKIP, PH_PAL_COUNT, PH_PAL_SKIP, PH_PAL_NUM,
    PH_PAL_DATA, PH_WD_COUNT, PH_WD_OP, PH_WD_PSKIP, PH_WD_PCNT, PH_WD_LIT,
    PH_WD_FILL0, PH_WD_FILL1, PH_BD_SKIPL, PH_BD_LINES, PH_BD_PKTS,
    PH_BD_PSKIP, PH_BD_PSIZE, PH_BD_LIT, PH_BD_FILL, PH_BR_LCNT, PH_BR_CNT,
    PH_BR_LIT, PH_BR_FILL, PH_BR_ZERO, PH_RAW
  } phase_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       record_start;
  } in_t;

  typedef struct packed {
    logic        write_valid;
    logic        write_target;
    logic [21:0] start_address;
    logic [22:0] run_length;
    logic [7:0]  first_value;
    logic [7:0]  second_value;
    logic        alternate;
    logic        frame_end;
    logic        malformed;
  } out_t;

  typedef struct packed {
    logic        en;
    logic        target;
    logic [22:0] addr;
    logic [22:0] len;
    logic [7:0]  v1;
    logic [7:0]  v2;
    logic        alt;
  } wreq_t;

  function automatic logic [22:0] sat_add(input logic [22:0] a, input logic [25:0] b);
    logic [26:0] s;
    s = {4'b0, a} + {1'b0, b};
    return (s > {4'b0, CUR_MAX}) ? CUR_MAX : s[22:0];
  endfunction

endpackage

@@ hdl/fcd_clip.sv @@
// bounds check and clipping of one write request against its target memory
module fcd_clip import fcd_pkg::*; (
  input  wreq_t       req,
  input  logic [22:0] area,
  output out_t        res
);

  logic [22:0] size;
  logic [22:0] room;

  always_comb begin
    size = (req.target == TGT_PALETTE) ? 23'(PALETTE_BYTES) : area;
    room = size - req.addr;
    res  = '0;
    if (req.en) begin
      if (req.addr >= size) begin
        res.malformed = 1'b1;
      end else begin
        res.write_valid   = 1'b1;
        res.write_target  = req.target;
        res.start_address = req.addr[21:0];
        res.first_value   = req.v1;
        res.second_value  = req.alt ? req.v2 : 8'd0;
        res.alternate     = req.alt;
        if (req.len > room) begin
          res.run_length = room;
          res.malformed  = 1'b1;
        end else begin
          res.run_length = req.len;
        end
      end
    end
  end

endmodule

@@ hdl/flc_frame_chunk_decoder.sv @@
// top level: frame record parser, chunk decoders and result register
//
// Usage: frame record bytes enter on the in_ channel (in_valid, in_stall,
// in_data), one byte per request; record_start marks the first byte of a
// record. Each byte yields at most one result on the out_ channel: a write
// command for the image or palette memory, a frame end mark, or a
// malformed flag. Image width and height are set through cfg_wr_en,
// cfg_index and cfg_data while no byte is in flight.
// The result of a byte is registered and is on out_data in the cycle after
// the byte is taken. Throughput: one byte per cycle while in_stall is low,
// set by the single parser update between state and result registers.
// Reset (rst_n low, synchronous) puts the parser in idle, waiting for a
// record start, and the dimensions back to 320 by 200.
// When the receiver stalls, the result register holds its request and
// in_stall rises only while a held result is still waiting, so bytes that
// yield no result flow on as soon as the register is free.
module flc_frame_chunk_decoder import fcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] rec_r, rec_nxt;
  logic [31:0] cbl_r, cbl_nxt;
  logic [15:0] chunks_r, chunks_nxt;
  logic        pal6_r, pal6_nxt;
  logic [3:0]  fidx_r, fidx_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [22:0] la_r, la_nxt;
  logic [22:0] wc_r, wc_nxt;
  logic [15:0] ll_r, ll_nxt;
  logic [15:0] pk_r, pk_nxt;
  logic [9:0]  rbl_r, rbl_nxt;
  logic [11:0] wl_r, wl_nxt;
  logic [11:0] pc_r, pc_nxt;
  logic [7:0]  held_r, held_nxt;

  logic [11:0] width_r, height_r;
  logic [22:0] area_r;
  logic [11:0] cfg_v;

  logic        out_valid_r, out_valid_nxt;
  out_t        out_r;

  logic        accept;
  wreq_t       req;
  out_t        wres;
  out_t        res;
  logic        has_res;
  logic        fend, mal;

  phase_t      ph;
  logic [3:0]  fidx_c, fidx_inc;
  logic [31:0] acc_c, fld;
  logic [31:0] rec_c;
  logic [7:0]  b;
  logic        pk_done, ln_done, ck_end;
  phase_t      pk_skip, pk_lstart, ln_next;
  logic [8:0]  nb;
  logic [9:0]  nb3, b3;
  logic [12:0] pcs;
  logic [14:0] lsk;
  logic [26:0] skp;
  logic [27:0] bdp;
  logic [11:0] wl_t;
  logic [15:0] ll_dec, pk_dec;
  logic [9:0]  rbl_dec;
  logic [8:0]  neg;

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  fcd_clip u_clip (
    .req  (req),
    .area (area_r),
    .res  (wres)
  );

  always_comb begin
    phase_nxt  = phase_r;
    rec_nxt    = rec_r;
    cbl_nxt    = cbl_r;
    chunks_nxt = chunks_r;
    pal6_nxt   = pal6_r;
    fidx_nxt   = fidx_r;
    acc_nxt    = acc_r;
    la_nxt     = la_r;
    wc_nxt     = wc_r;
    ll_nxt     = ll_r;
    pk_nxt     = pk_r;
    rbl_nxt    = rbl_r;
    wl_nxt     = wl_r;
    pc_nxt     = pc_r;
    held_nxt   = held_r;
    req        = '0;
    fend       = 1'b0;
    mal        = 1'b0;
    pk_done    = 1'b0;
    ln_done    = 1'b0;
    ck_end     = 1'b0;
    pk_skip    = PH_CHK_SKIP;
    pk_lstart  = PH_CHK_SKIP;
    ln_next    = PH_CHK_SKIP;

    b      = in_data.frame_byte;
    ph     = in_data.record_start ? PH_REC_SIZE : phase_r;
    fidx_c = in_data.record_start ? 4'd0 : fidx_r;
    acc_c  = in_data.record_start ? 32'd0 : acc_r;
    rec_c  = in_data.record_start ? 32'd0 : rec_r;
    if (in_data.record_start) begin
      phase_nxt = PH_REC_SIZE;
      fidx_nxt  = 4'd0;
      acc_nxt   = 32'd0;
      rec_nxt   = 32'd0;
    end

    fld      = acc_c | ({24'd0, b} << {fidx_c[1:0], 3'b000});
    fidx_inc = fidx_c + 4'd1;
    nb       = (b == 8'd0) ? 9'd256 : {1'b0, b};
    nb3      = {1'b0, nb} + {nb, 1'b0};
    b3       = {2'b0, b} + {1'b0, b, 1'b0};
    pcs      = {1'b0, pc_r} + {3'b0, b3};
    lsk      = 15'(16'd0 - fld[15:0]);
    skp      = {15'd0, width_r} * {12'd0, lsk};
    bdp      = {12'd0, fld[15:0]} * {16'd0, width_r};
    neg      = 9'd256 - {1'b0, b};
    rbl_dec  = rbl_r - 10'd1;
    ll_dec   = ll_r - 16'd1;
    pk_dec   = pk_r - 16'd1;
    wl_t     = wl_r;

    if (ph == PH_IDLE) begin
      // bytes outside a record are dropped
    end else if (ph == PH_REC_SIZE) begin
      acc_nxt  = fld;
      fidx_nxt = fidx_inc;
      if (fidx_inc >= 4'd4) begin
        fidx_nxt = 4'd0;
        acc_nxt  = 32'd0;
        if (fld <= 32'd4) begin
          fend      = 1'b1;
          mal       = 1'b1;
          phase_nxt = PH_IDLE;
        end else begin
          rec_nxt   = fld - 32'd4;
          phase_nxt = PH_REC_TYPE;
        end
      end
    end else begin
      case (ph)
        PH_REC_TYPE: begin
          acc_nxt  = fld;
          fidx_nxt = fidx_inc;
          if (fidx_inc >= 4'd2) begin
            fidx_nxt  = 4'd0;
            acc_nxt   = 32'd0;
            phase_nxt = (fld[15:0] == FRAME_ID) ? PH_FRM_HDR : PH_REC_SKIP;
          end
        end
        PH_FRM_HDR: begin
          if (fidx_c < 4'd2) acc_nxt = fld;
          fidx_nxt = fidx_inc;
          if (fidx_inc >= 4'd10) begin
            fidx_nxt   = 4'd0;
            acc_nxt    = 32'd0;
            chunks_nxt = acc_c[15:0];
            phase_nxt  = (acc_c[15:0] != 16'd0) ? PH_CHK_SIZE : PH_REC_SKIP;
          end
        end
        PH_CHK_SIZE: begin
          acc_nxt  = fld;
          fidx_nxt = fidx_inc;
          if (fidx_inc >= 4'd4) begin
            fidx_nxt = 4'd0;
            acc_nxt  = 32'd0;
            if (fld < 32'd6) begin
              mal     = 1'b1;
              cbl_nxt = 32'd0;
            end else begin
              cbl_nxt = fld - 32'd6;
            end
            phase_nxt = PH_CHK_TYPE;
          end
        end
        PH_CHK_TYPE: begin
          acc_nxt  = fld;
          fidx_nxt = fidx_inc;
          if (fidx_inc >= 4'd2) begin
            fidx_nxt = 4'd0;
            acc_nxt  = 32'd0;
            pal6_nxt = (fld[15:0] == CK_PAL6);
            case (fld[15:0])
              CK_PAL8, CK_PAL6: begin
                phase_nxt = PH_PAL_COUNT;
                pc_nxt    = 12'd0;
              end
              CK_WDLT: begin
                phase_nxt = PH_WD_COUNT;
                la_nxt    = 23'd0;
              end
              CK_BDLT: phase_nxt = PH_BD_SKIPL;
              CK_CLEAR: begin
                req.en    = 1'b1;
                req.len   = area_r;
                phase_nxt = PH_CHK_SKIP;
              end
              CK_BRUN: begin
                phase_nxt = PH_BR_LCNT;
                ll_nxt    = {4'd0, height_r};
                wc_nxt    = 23'd0;
              end
              CK_RAW: begin
                phase_nxt = PH_RAW;
                wc_nxt    = 23'd0;
              end
              default: phase_nxt = PH_CHK_SKIP;
            endcase
            if (cbl_r == 32'd0) ck_end = 1'b1;
          end
        end
        PH_REC_SKIP: begin
        end
        default: begin
          case (ph)
            PH_PAL_COUNT: begin
              acc_nxt  = fld;
              fidx_nxt = fidx_inc;
              if (fidx_inc >= 4'd2) begin
                fidx_nxt  = 4'd0;
                acc_nxt   = 32'd0;
                pk_nxt    = fld[15:0];
                phase_nxt = (fld[15:0] != 16'd0) ? PH_PAL_SKIP : PH_CHK_SKIP;
              end
            end
            PH_PAL_SKIP: begin
              pc_nxt    = (pcs > {1'b0, PAL_MAX}) ? PAL_MAX : pcs[11:0];
              phase_nxt = PH_PAL_NUM;
            end
            PH_PAL_NUM: begin
              rbl_nxt   = nb3;
              phase_nxt = PH_PAL_DATA;
            end
            PH_PAL_DATA: begin
              req.en     = 1'b1;
              req.target = TGT_PALETTE;
              req.addr   = {11'd0, pc_r};
              req.len    = 23'd1;
              req.v1     = pal6_r ? {b[5:0], 2'b00} : b;
              if (pc_r < PAL_MAX) pc_nxt = pc_r + 12'd1;
              rbl_nxt = rbl_dec;
              if (rbl_dec == 10'd0) begin
                pk_dec    = pk_r - 16'd1;
                pk_nxt    = pk_dec;
                phase_nxt = (pk_dec != 16'd0) ? PH_PAL_SKIP : PH_CHK_SKIP;
              end
            end
            PH_WD_COUNT: begin
              acc_nxt  = fld;
              fidx_nxt = fidx_inc;
              if (fidx_inc >= 4'd2) begin
                fidx_nxt  = 4'd0;
                acc_nxt   = 32'd0;
                ll_nxt    = fld[15:0];
                la_nxt    = 23'd0;
                phase_nxt = (fld[15:0] != 16'd0) ? PH_WD_OP : PH_CHK_SKIP;
              end
            end
            PH_WD_OP: begin
              acc_nxt  = fld;
              fidx_nxt = fidx_inc;
              if (fidx_inc >= 4'd2) begin
                fidx_nxt = 4'd0;
                acc_nxt  = 32'd0;
                if (fld[15:0] >= OP_SKIP) begin
                  la_nxt = sat_add(la_r, skp[25:0]);
                end else if (fld[15:0] >= OP_LAST) begin
                  req.en   = 1'b1;
                  req.addr = sat_add(la_r, {14'd0, width_r - 12'd1});
                  req.len  = 23'd1;
                  req.v1   = fld[7:0];
                end else begin
                  pk_nxt = fld[15:0];
                  wc_nxt = la_r;
                  if (fld[15:0] == 16'd0) begin
                    ln_done = 1'b1;
                    ln_next = PH_WD_OP;
                  end else begin
                    phase_nxt = PH_WD_PSKIP;
                  end
                end
              end
            end
            PH_WD_PSKIP, PH_BD_PSKIP: begin
              wc_nxt    = sat_add(wc_r, {18'd0, b});
              phase_nxt = (ph == PH_WD_PSKIP) ? PH_WD_PCNT : PH_BD_PSIZE;
            end
            PH_WD_PCNT: begin
              if (!b[7]) begin
                if (b == 8'd0) begin
                  pk_done   = 1'b1;
                  pk_skip   = PH_WD_PSKIP;
                  pk_lstart = PH_WD_OP;
                end else begin
                  rbl_nxt   = {1'b0, b, 1'b0};
                  phase_nxt = PH_WD_LIT;
                end
              end else begin
                rbl_nxt   = {1'b0, neg};
                phase_nxt = PH_WD_FILL0;
              end
            end
            PH_WD_LIT, PH_BD_LIT: begin
              req.en   = 1'b1;
              req.addr = wc_r;
              req.len  = 23'd1;
              req.v1   = b;
              wc_nxt   = sat_add(wc_r, 26'd1);
              rbl_nxt  = rbl_dec;
              if (rbl_dec == 10'd0) begin
                pk_done = 1'b1;
                if (ph == PH_WD_LIT) begin
                  pk_skip   = PH_WD_PSKIP;
                  pk_lstart = PH_WD_OP;
                end else begin
                  pk_skip   = PH_BD_PSKIP;
                  pk_lstart = PH_BD_PKTS;
                end
              end
            end
            PH_WD_FILL0: begin
              held_nxt  = b;
              phase_nxt = PH_WD_FILL1;
            end
            PH_WD_FILL1: begin
              req.en    = 1'b1;
              req.addr  = wc_r;
              req.len   = {12'd0, rbl_r, 1'b0};
              req.v1    = held_r;
              req.v2    = b;
              req.alt   = 1'b1;
              wc_nxt    = sat_add(wc_r, {15'd0, rbl_r, 1'b0});
              pk_done   = 1'b1;
              pk_skip   = PH_WD_PSKIP;
              pk_lstart = PH_WD_OP;
            end
            PH_BD_SKIPL: begin
              acc_nxt  = fld;
              fidx_nxt = fidx_inc;
              if (fidx_inc >= 4'd2) begin
                fidx_nxt  = 4'd0;
                acc_nxt   = 32'd0;
                la_nxt    = (bdp > {5'd0, CUR_MAX}) ? CUR_MAX : bdp[22:0];
                phase_nxt = PH_BD_LINES;
              end
            end
            PH_BD_LINES: begin
              acc_nxt  = fld;
              fidx_nxt = fidx_inc;
              if (fidx_inc >= 4'd2) begin
                fidx_nxt  = 4'd0;
                acc_nxt   = 32'd0;
                ll_nxt    = fld[15:0];
                phase_nxt = (fld[15:0] != 16'd0) ? PH_BD_PKTS : PH_CHK_SKIP;
              end
            end
            PH_BD_PKTS: begin
              pk_nxt = {8'd0, b};
              wc_nxt = la_r;
              if (b == 8'd0) begin
                ln_done = 1'b1;
                ln_next = PH_BD_PKTS;
              end else begin
                phase_nxt = PH_BD_PSKIP;
              end
            end
            PH_BD_PSIZE: begin
              if (!b[7]) begin
                if (b == 8'd0) begin
                  pk_done   = 1'b1;
                  pk_skip   = PH_BD_PSKIP;
                  pk_lstart = PH_BD_PKTS;
                end else begin
                  rbl_nxt   = {2'b0, b};
                  phase_nxt = PH_BD_LIT;
                end
              end else begin
                rbl_nxt   = {1'b0, neg};
                phase_nxt = PH_BD_FILL;
              end
            end
            PH_BD_FILL: begin
              req.en    = 1'b1;
              req.addr  = wc_r;
              req.len   = {13'd0, rbl_r};
              req.v1    = b;
              wc_nxt    = sat_add(wc_r, {16'd0, rbl_r});
              pk_done   = 1'b1;
              pk_skip   = PH_BD_PSKIP;
              pk_lstart = PH_BD_PKTS;
            end
            PH_BR_LCNT: begin
              wl_nxt    = width_r;
              phase_nxt = PH_BR_CNT;
            end
            PH_BR_CNT: begin
              if (b[7]) begin
                rbl_nxt   = {1'b0, neg};
                phase_nxt = PH_BR_LIT;
              end else if (b != 8'd0) begin
                rbl_nxt   = {2'b0, b};
                phase_nxt = PH_BR_FILL;
              end else begin
                phase_nxt = PH_BR_ZERO;
              end
            end
            PH_BR_LIT, PH_BR_FILL: begin
              req.en   = 1'b1;
              req.addr = wc_r;
              req.v1   = b;
              if (ph == PH_BR_LIT) begin
                req.len = 23'd1;
                wc_nxt  = sat_add(wc_r, 26'd1);
                wl_t    = (wl_r != 12'd0) ? wl_r - 12'd1 : 12'd0;
              end else begin
                req.len = {13'd0, rbl_r};
                wc_nxt  = sat_add(wc_r, {16'd0, rbl_r});
                wl_t    = ({2'b0, rbl_r} < wl_r) ? wl_r - {2'b0, rbl_r} : 12'd0;
              end
              wl_nxt  = wl_t;
              rbl_nxt = (ph == PH_BR_LIT) ? rbl_dec : rbl_r;
              if (ph == PH_BR_FILL || rbl_dec == 10'd0) begin
                if (wl_t == 12'd0) begin
                  ll_dec    = ll_r - 16'd1;
                  ll_nxt    = ll_dec;
                  phase_nxt = (ll_dec != 16'd0) ? PH_BR_LCNT : PH_CHK_SKIP;
                end else begin
                  phase_nxt = PH_BR_CNT;
                end
              end
            end
            PH_BR_ZERO: phase_nxt = PH_BR_CNT;
            PH_RAW: begin
              req.en   = 1'b1;
              req.addr = wc_r;
              req.len  = 23'd1;
              req.v1   = b;
              wc_nxt   = sat_add(wc_r, 26'd1);
              if (sat_add(wc_r, 26'd1) >= area_r) phase_nxt = PH_CHK_SKIP;
            end
            default: begin
            end
          endcase

          if (pk_done) begin
            pk_dec = pk_r - 16'd1;
            pk_nxt = pk_dec;
            if (pk_dec != 16'd0) begin
              phase_nxt = pk_skip;
            end else begin
              ln_done = 1'b1;
              ln_next = pk_lstart;
            end
          end
          if (ln_done) begin
            la_nxt    = sat_add(la_r, {14'd0, width_r});
            ll_dec    = ll_r - 16'd1;
            ll_nxt    = ll_dec;
            phase_nxt = (ll_dec != 16'd0) ? ln_next : PH_CHK_SKIP;
          end

          cbl_nxt = cbl_r - 32'd1;
          if (cbl_nxt == 32'd0) ck_end = 1'b1;
        end
      endcase

      if (ck_end) begin
        if (phase_nxt != PH_CHK_SKIP) mal = 1'b1;
        fidx_nxt   = 4'd0;
        acc_nxt    = 32'd0;
        chunks_nxt = chunks_r - 16'd1;
        phase_nxt  = (chunks_nxt != 16'd0) ? PH_CHK_SIZE : PH_REC_SKIP;
      end

      rec_nxt = rec_c - 32'd1;
      if (rec_nxt == 32'd0) begin
        fend = 1'b1;
        if (phase_nxt != PH_REC_SKIP) mal = 1'b1;
        phase_nxt = PH_IDLE;
      end
    end
  end

  always_comb begin
    res           = wres;
    res.frame_end = fend;
    res.malformed = wres.malformed | mal;
    has_res       = res.write_valid | res.frame_end | res.malformed;
    out_valid_nxt = out_valid_r && out_stall;
    if (accept && has_res) out_valid_nxt = 1'b1;
  end

  always_comb begin
    cfg_v = cfg_data;
    if (cfg_v == 12'd0) cfg_v = 12'd1;
    if (cfg_v > 12'(MAX_DIMENSION)) cfg_v = 12'(MAX_DIMENSION);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      rec_r       <= '0;
      cbl_r       <= '0;
      chunks_r    <= '0;
      pal6_r      <= 1'b0;
      fidx_r      <= '0;
      acc_r       <= '0;
      la_r        <= '0;
      wc_r        <= '0;
      ll_r        <= '0;
      pk_r        <= '0;
      rbl_r       <= '0;
      wl_r        <= '0;
      pc_r        <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
      area_r      <= AREA_RST;
    end else begin
      if (accept) begin
        phase_r  <= phase_nxt;
        rec_r    <= rec_nxt;
        cbl_r    <= cbl_nxt;
        chunks_r <= chunks_nxt;
        pal6_r   <= pal6_nxt;
        fidx_r   <= fidx_nxt;
        acc_r    <= acc_nxt;
        la_r     <= la_nxt;
        wc_r     <= wc_nxt;
        ll_r     <= ll_nxt;
        pk_r     <= pk_nxt;
        rbl_r    <= rbl_nxt;
        wl_r     <= wl_nxt;
        pc_r     <= pc_nxt;
        held_r   <= held_nxt;
      end
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        if (cfg_index == CFG_WIDTH) begin
          width_r <= cfg_v;
          area_r  <= 23'({11'd0, cfg_v} * {11'd0, height_r});
        end else begin
          height_r <= cfg_v;
          area_r   <= 23'({11'd0, width_r} * {11'd0, cfg_v});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_res) out_r <= res;
  end

`ifndef SYNTHESIS
  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.write_valid |-> out_r.run_length != 23'd0)
    else $error("write request with zero length");

  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.write_valid |->
      out_r.start_address == 22'd0 && out_r.run_length == 23'd0 && !out_r.alternate)
    else $error("fields set on request without write");

  a_pal_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.write_valid && out_r.write_target == TGT_PALETTE |->
      {2'b0, out_r.start_address} + {1'b0, out_r.run_length} <= 24'(PALETTE_BYTES))
    else $error("palette write past end");

  a_img_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.write_valid && out_r.write_target == TGT_IMAGE |->
      {2'b0, out_r.start_address} + {1'b0, out_r.run_length} <= {1'b0, area_r})
    else $error("image write past end");
`endif

endmodule
